[design/rcfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP command frame parser package
// Shared constants, result codes, the byte class record and name tables.
// ----------------------------------------------------------------------------
package rcfp_pkg;

   // Field widths of the two channels
   localparam int DATA_W      = 8;
   localparam int ARG_INDEX_W = 10;
   localparam int ARG_COUNT_W = 11;
   localparam int VERDICT_W   = 2;

   // Defaults for the top-level bounds
   localparam int DEF_MAX_ARG_COUNT = 1024;
   localparam int DEF_MAX_BULK_LEN  = 1048576;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_PING      = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_SET       = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN   = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_MALFORMED = 2'd3;

   // Byte values the parser looks for
   localparam logic [DATA_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [DATA_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [DATA_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [DATA_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [DATA_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [DATA_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [DATA_W-1:0] CHAR_LOW_A  = 8'h61;
   localparam logic [DATA_W-1:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

   // One classified input byte, as it travels from front to back
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              eom;
      logic              is_digit;
      logic [3:0]        digit;
      logic              is_cr;
      logic              is_lf;
      logic              is_star;
      logic              is_dollar;
   } byte_class_type;

   // Fold lower-case ASCII letters to upper case
   function automatic logic [DATA_W-1:0] to_upper(input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = b;
      if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
         r = b - CASE_OFFSET;
      end
      return r;
   endfunction

   // Letters of the PING command name
   function automatic logic [DATA_W-1:0] ping_char(input logic [1:0] pos);
      logic [DATA_W-1:0] r;
      case (pos)
         2'd0:    r = 8'h50;
         2'd1:    r = 8'h49;
         2'd2:    r = 8'h4E;
         default: r = 8'h47;
      endcase
      return r;
   endfunction

   // Letters of the SET command name; the fourth place never matches
   function automatic logic [DATA_W-1:0] set_char(input logic [1:0] pos);
      logic [DATA_W-1:0] r;
      case (pos)
         2'd0:    r = 8'h53;
         2'd1:    r = 8'h45;
         2'd2:    r = 8'h54;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

[design/rcfp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP command frame parser channel interfaces
// Valid/ready channels for message bytes in and parse results out.
// ----------------------------------------------------------------------------
interface rcfp_req_if;
   logic                       valid;
   logic                       ready;
   logic [rcfp_pkg::DATA_W-1:0] data_byte;
   logic                       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface rcfp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            is_verdict;
   logic [rcfp_pkg::DATA_W-1:0]      payload_byte;
   logic [rcfp_pkg::ARG_INDEX_W-1:0] arg_index;
   logic                            arg_last;
   logic [rcfp_pkg::VERDICT_W-1:0]   verdict;
   logic [rcfp_pkg::ARG_COUNT_W-1:0] arg_count;

   modport source (output valid, output is_verdict, output payload_byte, output arg_index,
                   output arg_last, output verdict, output arg_count, input ready);
   modport sink   (input valid, input is_verdict, input payload_byte, input arg_index,
                   input arg_last, input verdict, input arg_count, output ready);
endinterface

[design/rcfp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP parser front end
// Takes message bytes off the request channel and classifies them.
// ----------------------------------------------------------------------------
module rcfp_front (
   rcfp_req_if.sink                req_chan,
   input  logic                    queue_full,
   output logic                    push,
   output rcfp_pkg::byte_class_type entry
);
   import rcfp_pkg::*;

   logic [DATA_W-1:0] b;

   assign b              = req_chan.data_byte;
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   always_comb begin
      entry           = '0;
      entry.data_byte = b;
      entry.eom       = req_chan.end_of_message;
      entry.is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      entry.digit     = b[3:0];
      entry.is_cr     = (b == CHAR_CR);
      entry.is_lf     = (b == CHAR_LF);
      entry.is_star   = (b == CHAR_STAR);
      entry.is_dollar = (b == CHAR_DOLLAR);
   end

endmodule

[design/rcfp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP parser byte queue
// Short first-in first-out buffer of classified bytes between front and back.
// ----------------------------------------------------------------------------
module rcfp_queue #(
   parameter int DEPTH = rcfp_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rcfp_pkg::byte_class_type push_data,
   input  logic                     pop,
   output rcfp_pkg::byte_class_type pop_data,
   output logic                     empty,
   output logic                     full
);
   import rcfp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   byte_class_type store_ff [DEPTH];
   logic [AW:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count;

   assign count    = wr_ptr_ff - rd_ptr_ff;
   assign empty    = (count == '0);
   assign full     = (count == (AW+1)'(DEPTH));
   assign pop_data = store_ff[rd_ptr_ff[AW-1:0]];

   // Pointers wrap at the depth, which is a power of two
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

[design/rcfp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP parser back end
// Frame state machine over classified bytes, with a registered result stage.
// ----------------------------------------------------------------------------
module rcfp_back #(
   parameter int MAX_ARG_COUNT = rcfp_pkg::DEF_MAX_ARG_COUNT,
   parameter int MAX_BULK_LEN  = rcfp_pkg::DEF_MAX_BULK_LEN
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  rcfp_pkg::byte_class_type item,
   output logic                     pop,
   rcfp_rsp_if.source               rsp_chan
);
   import rcfp_pkg::*;

   localparam int CNT_W = $clog2(MAX_ARG_COUNT + 1);
   localparam int LEN_W = $clog2(MAX_BULK_LEN + 1);
   localparam int ACC_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int EXT_W = ACC_W + 4;

   localparam logic [EXT_W-1:0] CNT_BOUND = EXT_W'(MAX_ARG_COUNT);
   localparam logic [EXT_W-1:0] LEN_BOUND = EXT_W'(MAX_BULK_LEN);

   typedef enum logic [3:0] {
      PH_STAR, PH_CNT_DIG, PH_CNT_MORE, PH_CNT_LF, PH_DOLLAR, PH_LEN_DIG,
      PH_LEN_MORE, PH_LEN_LF, PH_PAYLOAD, PH_PAY_CR, PH_PAY_LF, PH_DONE, PH_ERROR
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  args_ff, args_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [2:0]        pos_ff, pos_in;
   logic [1:0]        flags_ff, flags_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_is_verdict_ff;
   logic [DATA_W-1:0]      rsp_payload_ff;
   logic [ARG_INDEX_W-1:0] rsp_index_ff;
   logic                   rsp_last_ff;
   logic [VERDICT_W-1:0]   rsp_verdict_ff;
   logic [ARG_COUNT_W-1:0] rsp_count_ff;

   logic                   out_space;
   logic                   emit;
   logic                   last_byte;
   logic [EXT_W-1:0]       acc_next;
   logic [EXT_W-1:0]       digit_bound;
   logic [CNT_W:0]         cur_inc;
   logic [DATA_W-1:0]      upper;
   logic [VERDICT_W-1:0]   verdict;
   logic [CNT_W+ARG_COUNT_W-1:0] count_wide;
   logic [CNT_W+ARG_INDEX_W-1:0] index_wide;

   // A result slot is free when empty or being drained this cycle
   assign out_space = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = !queue_empty && out_space;

   assign acc_next    = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + EXT_W'(item.digit);
   assign digit_bound = (phase_ff == PH_CNT_DIG || phase_ff == PH_CNT_MORE) ?
                        CNT_BOUND : LEN_BOUND;
   assign cur_inc     = {1'b0, cur_ff} + 1'b1;
   assign upper       = to_upper(item.data_byte);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      args_in   = args_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;
      flags_in  = flags_ff;
      emit      = 1'b0;
      last_byte = 1'b0;
      case (phase_ff)
         PH_STAR: begin
            if (item.is_star) begin
               acc_in   = '0;
               phase_in = PH_CNT_DIG;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_CNT_DIG, PH_CNT_MORE, PH_LEN_DIG, PH_LEN_MORE: begin
            if (item.is_digit) begin
               if (acc_next <= digit_bound) begin
                  acc_in   = acc_next[ACC_W-1:0];
                  phase_in = (phase_ff == PH_CNT_DIG || phase_ff == PH_CNT_MORE) ?
                             PH_CNT_MORE : PH_LEN_MORE;
               end else begin
                  phase_in = PH_ERROR;
               end
            end else if (item.is_cr && phase_ff == PH_CNT_MORE) begin
               phase_in = PH_CNT_LF;
            end else if (item.is_cr && phase_ff == PH_LEN_MORE) begin
               phase_in = PH_LEN_LF;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_CNT_LF: begin
            if (item.is_lf && acc_ff != '0) begin
               args_in  = acc_ff[CNT_W-1:0];
               cur_in   = '0;
               phase_in = PH_DOLLAR;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_DOLLAR: begin
            if (item.is_dollar) begin
               acc_in   = '0;
               phase_in = PH_LEN_DIG;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_LEN_LF: begin
            if (item.is_lf) begin
               rem_in   = acc_ff[LEN_W-1:0];
               phase_in = (acc_ff == '0) ? PH_PAY_CR : PH_PAYLOAD;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_PAYLOAD: begin
            if (cur_ff == '0) begin
               if (pos_ff >= 3'd4 || upper != ping_char(pos_ff[1:0])) begin
                  flags_in[0] = 1'b0;
               end
               if (pos_ff >= 3'd3 || upper != set_char(pos_ff[1:0])) begin
                  flags_in[1] = 1'b0;
               end
               if (pos_ff != 3'd7) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            emit      = 1'b1;
            last_byte = (rem_ff == LEN_W'(1));
            rem_in    = rem_ff - 1'b1;
            if (last_byte) begin
               phase_in = PH_PAY_CR;
            end
         end
         PH_PAY_CR: begin
            phase_in = item.is_cr ? PH_PAY_LF : PH_ERROR;
         end
         PH_PAY_LF: begin
            if (item.is_lf) begin
               cur_in   = cur_inc[CNT_W-1:0];
               phase_in = (cur_inc >= {1'b0, args_ff}) ? PH_DONE : PH_DOLLAR;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // Verdict from the state as it stands after this byte
   always_comb begin
      if (phase_in != PH_DONE) begin
         verdict = VERDICT_MALFORMED;
      end else if (flags_in[0] && pos_in == 3'd4) begin
         verdict = VERDICT_PING;
      end else if (flags_in[1] && pos_in == 3'd3) begin
         verdict = VERDICT_SET;
      end else begin
         verdict = VERDICT_UNKNOWN;
      end
   end

   assign count_wide = {{ARG_COUNT_W{1'b0}}, args_in};
   assign index_wide = {{ARG_INDEX_W{1'b0}}, cur_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_space) begin
         rsp_valid_in = pop && (item.eom || emit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STAR;
         acc_ff       <= '0;
         args_ff      <= '0;
         cur_ff       <= '0;
         rem_ff       <= '0;
         pos_ff       <= '0;
         flags_ff     <= 2'b11;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop && item.eom) begin
            phase_ff <= PH_STAR;
            acc_ff   <= '0;
            args_ff  <= '0;
            cur_ff   <= '0;
            rem_ff   <= '0;
            pos_ff   <= '0;
            flags_ff <= 2'b11;
         end else if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            args_ff  <= args_in;
            cur_ff   <= cur_in;
            rem_ff   <= rem_in;
            pos_ff   <= pos_in;
            flags_ff <= flags_in;
         end
      end
      if (pop && item.eom) begin
         rsp_is_verdict_ff <= 1'b1;
         rsp_payload_ff    <= '0;
         rsp_index_ff      <= '0;
         rsp_last_ff       <= 1'b0;
         rsp_verdict_ff    <= verdict;
         rsp_count_ff      <= count_wide[ARG_COUNT_W-1:0];
      end else if (pop && emit) begin
         rsp_is_verdict_ff <= 1'b0;
         rsp_payload_ff    <= item.data_byte;
         rsp_index_ff      <= index_wide[ARG_INDEX_W-1:0];
         rsp_last_ff       <= last_byte;
         rsp_verdict_ff    <= VERDICT_PING;
         rsp_count_ff      <= count_wide[ARG_COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_verdict   = rsp_is_verdict_ff;
   assign rsp_chan.payload_byte = rsp_payload_ff;
   assign rsp_chan.arg_index    = rsp_index_ff;
   assign rsp_chan.arg_last     = rsp_last_ff;
   assign rsp_chan.verdict      = rsp_verdict_ff;
   assign rsp_chan.arg_count    = rsp_count_ff;

   a_restart_after_verdict: assert property (@(posedge clock) disable iff (reset)
      pop && item.eom |=> phase_ff == PH_STAR)
      else $error("parser did not restart after end of message");

   a_payload_pending: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != '0)
      else $error("payload phase with nothing left to take");

   a_arg_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DOLLAR || phase_ff == PH_LEN_DIG || phase_ff == PH_LEN_MORE ||
       phase_ff == PH_LEN_LF || phase_ff == PH_PAYLOAD || phase_ff == PH_PAY_CR ||
       phase_ff == PH_PAY_LF) |-> cur_ff < args_ff)
      else $error("argument index beyond declared count");

endmodule

[design/resp_command_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP command frame parser
// Parses '*count CRLF' then count bulk strings, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one message byte per transfer on req_chan and sustains one
// byte per clock while rsp_chan does not stall. Each payload byte of a bulk
// string comes out on rsp_chan with its argument index and a mark on the last
// byte of the argument; header and delimiter bytes give no result. The byte
// flagged end_of_message gives a verdict instead (ping, set, unknown command
// or malformed) together with the declared argument count, and the parser
// then starts afresh on the next message. A result passes through the front
// queue and then the result register before it is valid on rsp_chan. The
// four-entry queue lets the front keep taking bytes while a result waits at
// the output; req_chan.ready drops only once the queue is full. The argument
// count and bulk length bounds are the parameters MAX_ARG_COUNT and
// MAX_BULK_LEN; exceeding either, a count of zero, a missing marker or CRLF,
// or a message that stops short all give malformed.
module resp_command_frame_parser #(
   parameter int MAX_ARG_COUNT = rcfp_pkg::DEF_MAX_ARG_COUNT,
   parameter int MAX_BULK_LEN  = rcfp_pkg::DEF_MAX_BULK_LEN
) (
   input  logic         clock,
   input  logic         reset,
   rcfp_req_if.sink     req_chan,
   rcfp_rsp_if.source   rsp_chan
);
   import rcfp_pkg::*;

   // Classified byte on its way into the queue
   byte_class_type front_entry;
   // Classified byte at the head of the queue
   byte_class_type back_item;
   logic           push;
   logic           pop;
   logic           queue_empty;
   logic           queue_full;

   // Classify each transfer and push it into the queue
   rcfp_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .entry      (front_entry)
   );

   // Hold bytes here while the result side is stalled
   rcfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .pop       (pop),
      .pop_data  (back_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // Advance the frame state machine and register each result
   rcfp_back #(
      .MAX_ARG_COUNT (MAX_ARG_COUNT),
      .MAX_BULK_LEN  (MAX_BULK_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .item        (back_item),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

[dv/rcfp_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP frame parser scoreboard
// Byte-level predictor of the frame parser and the store of expected results.
// ----------------------------------------------------------------------------
package rcfp_scoreboard_pkg;
   import rcfp_pkg::*;

   typedef struct packed {
      logic                   is_verdict;
      logic [DATA_W-1:0]      payload_byte;
      logic [ARG_INDEX_W-1:0] arg_index;
      logic                   arg_last;
      logic [VERDICT_W-1:0]   verdict;
      logic [ARG_COUNT_W-1:0] arg_count;
   } parse_result_type;

   typedef enum logic [3:0] {
      ST_STAR, ST_CNT_FIRST, ST_CNT_MORE, ST_CNT_LF,
      ST_DOLLAR, ST_LEN_FIRST, ST_LEN_MORE, ST_LEN_LF,
      ST_PAYLOAD, ST_PAY_CR, ST_PAY_LF, ST_DONE, ST_ERROR
   } parse_stage_type;

   localparam int MAX_REPORTS = 10;

   class frame_scoreboard;
      parse_stage_type  stage;
      int unsigned      digits_value;
      int unsigned      args_declared;
      int unsigned      arg_no;
      int unsigned      bytes_left;
      logic [2:0]       name_pos;
      logic             ping_ok;
      logic             set_ok;
      logic             broken;
      logic [7:0]       ping_word [4];
      logic [7:0]       set_word [3];
      parse_result_type expected_results [$];
      int unsigned      failures;

      function new();
         ping_word = '{8'h50, 8'h49, 8'h4E, 8'h47};
         set_word  = '{8'h53, 8'h45, 8'h54};
         failures  = 0;
         restart();
      endfunction

      function void restart();
         stage         = ST_STAR;
         digits_value  = 0;
         args_declared = 0;
         arg_no        = 0;
         bytes_left    = 0;
         name_pos      = '0;
         ping_ok       = 1'b1;
         set_ok        = 1'b1;
         broken        = 1'b0;
      endfunction

      function void abandon();
         broken = 1'b1;
         stage  = ST_ERROR;
      endfunction

      // Bound is checked per digit, so the value never passes it
      function bit add_digit(logic [7:0] b, int unsigned bound);
         int unsigned grown;
         grown = digits_value * 10 + (int'(b) - int'(CHAR_ZERO));
         if (grown > bound) begin
            return 1'b0;
         end
         digits_value = grown;
         return 1'b1;
      endfunction

      function void match_name(logic [7:0] b);
         logic [7:0] up;
         up = b;
         if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
            up = b - 8'h20;
         end
         if (name_pos >= 4 || up != ping_word[name_pos[1:0]]) begin
            ping_ok = 1'b0;
         end
         if (name_pos >= 3 || up != set_word[name_pos[1:0]]) begin
            set_ok = 1'b0;
         end
         if (name_pos < 7) begin
            name_pos++;
         end
      endfunction

      // Advance the predictor by one accepted byte and queue its result, if any
      function void note_byte(logic [7:0] b, logic eom);
         logic             is_digit;
         logic             emit;
         parse_result_type r;
         is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
         emit     = 1'b0;
         r        = '0;
         case (stage)
            ST_STAR: begin
               if (b == CHAR_STAR) begin
                  digits_value = 0;
                  stage        = ST_CNT_FIRST;
               end else begin
                  abandon();
               end
            end
            ST_CNT_FIRST, ST_CNT_MORE: begin
               if (is_digit) begin
                  if (add_digit(b, DEF_MAX_ARG_COUNT)) stage = ST_CNT_MORE;
                  else abandon();
               end else if (b == CHAR_CR && stage == ST_CNT_MORE) begin
                  stage = ST_CNT_LF;
               end else begin
                  abandon();
               end
            end
            ST_CNT_LF: begin
               if (b == CHAR_LF && digits_value != 0) begin
                  args_declared = digits_value;
                  arg_no        = 0;
                  stage         = ST_DOLLAR;
               end else begin
                  abandon();
               end
            end
            ST_DOLLAR: begin
               if (b == CHAR_DOLLAR) begin
                  digits_value = 0;
                  stage        = ST_LEN_FIRST;
               end else begin
                  abandon();
               end
            end
            ST_LEN_FIRST, ST_LEN_MORE: begin
               if (is_digit) begin
                  if (add_digit(b, DEF_MAX_BULK_LEN)) stage = ST_LEN_MORE;
                  else abandon();
               end else if (b == CHAR_CR && stage == ST_LEN_MORE) begin
                  stage = ST_LEN_LF;
               end else begin
                  abandon();
               end
            end
            ST_LEN_LF: begin
               if (b == CHAR_LF) begin
                  bytes_left = digits_value;
                  stage      = (bytes_left == 0) ? ST_PAY_CR : ST_PAYLOAD;
               end else begin
                  abandon();
               end
            end
            ST_PAYLOAD: begin
               if (arg_no == 0) begin
                  match_name(b);
               end
               emit           = 1'b1;
               r.payload_byte = b;
               r.arg_index    = ARG_INDEX_W'(arg_no);
               r.arg_last     = (bytes_left == 1);
               bytes_left--;
               if (bytes_left == 0) begin
                  stage = ST_PAY_CR;
               end
            end
            ST_PAY_CR: begin
               if (b == CHAR_CR) stage = ST_PAY_LF;
               else abandon();
            end
            ST_PAY_LF: begin
               if (b == CHAR_LF) begin
                  arg_no++;
                  stage = (arg_no >= args_declared) ? ST_DONE : ST_DOLLAR;
               end else begin
                  abandon();
               end
            end
            ST_DONE: begin
            end
            default: begin
               abandon();
            end
         endcase

         if (eom) begin
            r            = '0;
            r.is_verdict = 1'b1;
            if (stage != ST_DONE || broken) begin
               r.verdict = VERDICT_MALFORMED;
            end else if (ping_ok && name_pos == 4) begin
               r.verdict = VERDICT_PING;
            end else if (set_ok && name_pos == 3) begin
               r.verdict = VERDICT_SET;
            end else begin
               r.verdict = VERDICT_UNKNOWN;
            end
            r.arg_count = ARG_COUNT_W'(args_declared);
            expected_results.push_back(r);
            restart();
         end else if (emit) begin
            r.arg_count = ARG_COUNT_W'(args_declared);
            expected_results.push_back(r);
         end
      endfunction

      function string describe(parse_result_type r);
         return $sformatf("is_verdict=%0b byte=%02h index=%0d last=%0b verdict=%0d count=%0d",
                          r.is_verdict, r.payload_byte, r.arg_index, r.arg_last,
                          r.verdict, r.arg_count);
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("%s", msg);
         end
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type exp;
         if (expected_results.size() == 0) begin
            report({"result with nothing expected: ", describe(got)});
         end else begin
            exp = expected_results.pop_front();
            if (got !== exp) begin
               report({"mismatch: expected ", describe(exp), " got ", describe(got)});
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_results.size();
      endfunction

      function void finish_check();
         if (expected_results.size() != 0) begin
            report($sformatf("%0d expected results never arrived", expected_results.size()));
         end
      endfunction
   endclass

endpackage

[dv/resp_command_frame_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RESP command frame parser testbench
// Feeds directed and random RESP frames byte by byte, mostly under random
// sender and receiver stalls, predicts every payload byte and verdict, and
// checks each result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module resp_command_frame_parser_tb;
   import rcfp_pkg::*;
   import rcfp_scoreboard_pkg::*;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam int DRAIN_CYCLES   = 8;     // queue and result register, with margin
   localparam int PHASE_BYTES    = 300;   // about 1250 bytes with the directed frames

   logic clock = 1'b0;
   logic reset;

   rcfp_req_if req_if ();
   rcfp_rsp_if rsp_if ();

   resp_command_frame_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   frame_scoreboard sb = new();

   logic [7:0]       frame [$];      // bytes of the frame being built
   logic [7:0]       arg_bytes [$];  // payload of the bulk string being built
   parse_result_type seen;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      cycle_count = 0;
   string            near_names [6] = '{"PIN", "PINGS", "SE", "SETS", "PONG", "SAT"};

   always #10 clock = ~clock;

   // Give up at the limit; a healthy run ends long before it
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver stalls at random; one assignment per edge keeps ready race free
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watch both channels. Signals read here hold their values from before the
   // edge, so a transfer is seen exactly when the block sees it. Note the input
   // before checking the output, in case a result ever lands on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.data_byte, req_if.end_of_message);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen.is_verdict   = rsp_if.is_verdict;
            seen.payload_byte = rsp_if.payload_byte;
            seen.arg_index    = rsp_if.arg_index;
            seen.arg_last     = rsp_if.arg_last;
            seen.verdict      = rsp_if.verdict;
            seen.arg_count    = rsp_if.arg_count;
            sb.check_result(seen);
         end
      end
   end

   // Frame building: '|' stands for CR LF and '^' for a lone CR
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         case (s[i])
            "|": begin
               frame.push_back(CHAR_CR);
               frame.push_back(CHAR_LF);
            end
            "^": begin
               frame.push_back(CHAR_CR);
            end
            default: begin
               frame.push_back(s[i]);
            end
         endcase
      end
   endfunction

   function automatic void put_decimal(int unsigned n);
      string s;
      s = $sformatf("%0d", n);
      for (int i = 0; i < s.len(); i++) begin
         frame.push_back(s[i]);
      end
   endfunction

   // Wrap arg_bytes as one bulk string
   function automatic void put_bulk();
      frame.push_back(CHAR_DOLLAR);
      put_decimal(arg_bytes.size());
      put_text("|");
      foreach (arg_bytes[i]) frame.push_back(arg_bytes[i]);
      put_text("|");
   endfunction

   // Fill arg_bytes with a name in random letter case
   function automatic void put_word_mixed(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "A" && c <= "Z" && $urandom_range(1) == 1) begin
            c = c + 8'h20;
         end
         arg_bytes.push_back(c);
      end
   endfunction

   function automatic void put_random_bytes(int unsigned n);
      repeat (n) arg_bytes.push_back(8'($urandom_range(255)));
   endfunction

   // Mostly well-formed frames with random content; the rest are corrupted,
   // truncated, out of bounds or plain noise
   function automatic void build_random_frame();
      int unsigned n;
      int unsigned kind;
      int unsigned cut;
      frame.delete();
      n = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      frame.push_back(CHAR_STAR);
      if ($urandom_range(99) < 10) frame.push_back(CHAR_ZERO);
      put_decimal(n);
      put_text("|");
      for (int i = 0; i < n; i++) begin
         arg_bytes.delete();
         if (i == 0) begin
            case ($urandom_range(5))
               0, 1:    put_word_mixed("PING");
               2, 3:    put_word_mixed("SET");
               4:       put_word_mixed(near_names[$urandom_range(5)]);
               default: put_random_bytes($urandom_range(0, 6));
            endcase
         end else if ($urandom_range(99) < 5) begin
            put_random_bytes($urandom_range(9, 40));
         end else begin
            put_random_bytes($urandom_range(0, 8));
         end
         put_bulk();
      end
      // trailing bytes after the last argument are ignored by the parser
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
      end

      kind = $urandom_range(99);
      if (kind < 12) begin
         frame[$urandom_range(frame.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 24) begin
         cut = $urandom_range(1, frame.size() - 1);
         while (frame.size() > cut) void'(frame.pop_back());
      end else if (kind < 30) begin
         frame.delete();
         repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(255)));
      end else if (kind < 34) begin
         // counts and lengths around their bounds, cut short in the payload
         frame.delete();
         frame.push_back(CHAR_STAR);
         put_decimal($urandom_range(1000, 1100));
         put_text("|$");
         put_decimal($urandom_range(1048570, 1048580));
         put_text("|");
         repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Hold valid low for a random gap, then offer the byte until it transfers.
   // Valid is never dropped and raised in the same step.
   task automatic send_byte(input logic [7:0] b, input logic eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid          <= 1'b1;
      req_if.data_byte      <= b;
      req_if.end_of_message <= eom;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic send_text(input string s);
      frame.delete();
      put_text(s);
      send_frame();
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   initial begin
      int unsigned sent;
      send_idle_pct         = 22;
      recv_idle_pct         = 78;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.data_byte      <= '0;
      req_if.end_of_message <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: each command, case folding, empty argument, trailing
      // junk, count and length bounds, bad digits, missing markers and CRLFs,
      // truncation, and a frame ending on a payload byte
      send_text("*1|$4|PING|");
      send_text("*3|$3|set|$1|k|$2|vv|");
      send_text("*2|$4|pInG|$0||");
      send_text("*2|$3|SEt|$0||");
      send_text("*1|$0||");
      send_text("*001|$3|GET|xyz");
      send_text("*1|$5|PINGS|");
      send_text("*0|");
      send_text("*1025|");
      send_text("*1024|$1|A");
      send_text("*+1|$4|PING|");
      send_text("*1|$-1|");
      send_text("*1|$1048577|");
      send_text("*1|$1048576|ab");
      send_text("*1\n$4|PING|");
      send_text("*1^^");
      send_text("*1|#4|PING|");
      send_text("*1|$1|AB|");
      send_text("*|");
      send_text("*/|");
      send_text("*1:|");
      send_text("*1|$4|PING^");
      send_text("*");
      frame.delete();
      frame.push_back(8'h00);
      send_frame();
      frame.delete();
      put_text("*1|$2|");
      frame.push_back(8'hFF);
      frame.push_back(8'h00);
      put_text("|");
      send_frame();
      drain();

      // Random frames: sender light and receiver heavy, then the reverse,
      // then both flat out; drain between phases
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_random_frame();
            send_frame();
            sent += frame.size();
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.finish_check();
      if (sb.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
